FILE: design/autocorrelation_beat_tempo_assert.svh
// assertion macros for the beat tempo estimator
`ifndef AUTOCORRELATION_BEAT_TEMPO_ASSERT_SVH
`define AUTOCORRELATION_BEAT_TEMPO_ASSERT_SVH

// plain implication checked every clock outside reset
`define ACT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define ACT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/act_pkg.sv
// shared types and constants of the beat tempo estimator
`timescale 1ns / 1ps

package act_pkg;

  localparam int DECIMATION    = 16;
  localparam int LAG_COUNT     = 8192;
  localparam int HISTORY_DEPTH = 16384;

  localparam int LW      = $clog2(LAG_COUNT);
  localparam int HW      = $clog2(HISTORY_DEPTH);
  localparam int CLR_N   = (HISTORY_DEPTH > LAG_COUNT) ? HISTORY_DEPTH : LAG_COUNT;
  localparam int CW      = $clog2(CLR_N + 1);
  localparam int PW      = $clog2(DECIMATION + 1);
  localparam int SUM_W   = 48;
  localparam int SRCH_CAP = (LAG_COUNT < 4096) ? LAG_COUNT : 4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAMPLE,
    ST_SEARCH,
    ST_SHOW,
    ST_DECAY
  } state_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_SAMPLE,
    OP_SEARCH,
    OP_DECAY
  } mode_e;

  typedef enum logic [2:0] {
    REG_MIN_LAG,
    REG_SEARCH_RANGE,
    REG_CHECK_INTERVAL,
    REG_DECAY_FACTOR,
    REG_DECAY_INTERVAL
  } reg_e;

  typedef struct packed {
    mode_e         mode;
    logic          issue;
    logic [CW-1:0] idx;
    logic          v1;
    logic          hist_wr;
    logic          search_start;
    logic          search_done;
  } ctl_t;

endpackage

FILE: design/act_ctrl.sv
// sequencer: sweeps, tick counters and input handshake
`timescale 1ns / 1ps
`include "autocorrelation_beat_tempo_assert.svh"

module act_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 command_i,
  input  logic                 out_full_i,
  input  logic [9:0]           check_interval_i,
  input  logic [6:0]           decay_interval_i,
  input  logic [12:0]          search_range_i,
  output logic                 in_ready_o,
  output act_pkg::ctl_t        ctl_o
);

  act_pkg::state_e state_q, state_d;
  logic [act_pkg::CW-1:0] cnt_q, cnt_d;
  logic                   v1_q, v1_d;
  logic [act_pkg::PW-1:0] phase_q, phase_d;
  logic [9:0]             chk_q, chk_d;
  logic [6:0]             dcy_q, dcy_d;
  logic                   pend_q, pend_d;
  logic [31:0]            limit;
  logic [31:0]            range32;
  logic                   sweep, issue, drained, accept, due_srch, due_dcy;

  always_comb begin
    range32 = 32'(search_range_i);
    if (range32 > 32'(act_pkg::SRCH_CAP)) begin
      range32 = 32'(act_pkg::SRCH_CAP);
    end
    case (state_q)
      act_pkg::ST_CLEAR:  limit = 32'(act_pkg::CLR_N);
      act_pkg::ST_SEARCH: limit = range32;
      default:            limit = 32'(act_pkg::LAG_COUNT);
    endcase
    sweep = (state_q == act_pkg::ST_CLEAR) || (state_q == act_pkg::ST_SAMPLE) ||
            (state_q == act_pkg::ST_SEARCH) || (state_q == act_pkg::ST_DECAY);
    issue    = sweep && (32'(cnt_q) < limit);
    drained  = !issue && !v1_q;
    accept   = (state_q == act_pkg::ST_IDLE) && in_valid_i;
    due_srch = chk_q >= check_interval_i;
    due_dcy  = dcy_q >= decay_interval_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      act_pkg::ST_CLEAR: begin
        if (drained) state_d = act_pkg::ST_IDLE;
      end
      act_pkg::ST_IDLE: begin
        if (accept) begin
          if (!command_i) begin
            if (phase_q == '0) state_d = act_pkg::ST_SAMPLE;
          end else if (due_srch) begin
            state_d = act_pkg::ST_SEARCH;
          end else if (due_dcy) begin
            state_d = act_pkg::ST_DECAY;
          end
        end
      end
      act_pkg::ST_SAMPLE: begin
        if (drained) state_d = act_pkg::ST_IDLE;
      end
      act_pkg::ST_SEARCH: begin
        if (drained) state_d = act_pkg::ST_SHOW;
      end
      act_pkg::ST_SHOW: begin
        if (!out_full_i) state_d = pend_q ? act_pkg::ST_DECAY : act_pkg::ST_IDLE;
      end
      act_pkg::ST_DECAY: begin
        if (drained) state_d = act_pkg::ST_IDLE;
      end
      default: state_d = act_pkg::ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    in_ready_o = (state_q == act_pkg::ST_IDLE);
    case (state_q)
      act_pkg::ST_CLEAR:  ctl_o.mode = act_pkg::OP_CLEAR;
      act_pkg::ST_SAMPLE: ctl_o.mode = act_pkg::OP_SAMPLE;
      act_pkg::ST_SEARCH: ctl_o.mode = act_pkg::OP_SEARCH;
      act_pkg::ST_DECAY:  ctl_o.mode = act_pkg::OP_DECAY;
      default:            ctl_o.mode = act_pkg::OP_IDLE;
    endcase
    ctl_o.issue        = issue;
    ctl_o.idx          = cnt_q;
    ctl_o.v1           = v1_q;
    ctl_o.hist_wr      = accept && !command_i && (phase_q == '0);
    ctl_o.search_start = accept && command_i && due_srch;
    ctl_o.search_done  = (state_q == act_pkg::ST_SHOW) && !out_full_i;

    v1_d = issue && (state_q != act_pkg::ST_CLEAR);
    if (issue) begin
      cnt_d = cnt_q + 1'b1;
    end else if ((state_q == act_pkg::ST_IDLE) || (state_q == act_pkg::ST_SHOW)) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q;
    end

    phase_d = phase_q;
    chk_d   = chk_q;
    dcy_d   = dcy_q;
    pend_d  = pend_q;
    if (accept) begin
      if (!command_i) begin
        phase_d = (32'(phase_q) >= 32'(act_pkg::DECIMATION - 1)) ? '0 : phase_q + 1'b1;
      end else begin
        phase_d = '0;
        chk_d   = due_srch ? '0 : chk_q + 1'b1;
        dcy_d   = due_dcy ? '0 : dcy_q + 1'b1;
        pend_d  = due_dcy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= act_pkg::ST_CLEAR;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      phase_q <= '0;
      chk_q   <= '0;
      dcy_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= v1_d;
      phase_q <= phase_d;
      chk_q   <= chk_d;
      dcy_q   <= dcy_d;
      pend_q  <= pend_d;
    end
  end

  `ACT_ASSERT_IMP(a_ready_no_issue, in_ready_o, !issue && !v1_q, "ready during sweep")
  `ACT_ASSERT_NXT(a_issue_pipe, issue && (state_q != act_pkg::ST_CLEAR), v1_q, "lost stage")
  `ACT_ASSERT_IMP(a_done_drained, ctl_o.search_done, !v1_q && !issue, "search not drained")

endmodule

FILE: design/autocorrelation_beat_tempo.sv
// top level: config, memories, shared multiply-accumulate unit, result register
// a kept sample sweeps all LAG_COUNT lag sums, one lag sum per cycle through the shared multiplier
// a tick with a search sweeps search_range lags (capped at 4096), plus any wait for the result
// register, and may then run a decay sweep over all lags; a tick may also run a decay alone
// other samples and plain ticks are accepted without a sweep; a clearing pass over max(HISTORY_DEPTH,
// LAG_COUNT) entries after reset zeroes both memories; reset is asynchronous, active low
`timescale 1ns / 1ps

module autocorrelation_beat_tempo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         command_i,
  input  logic [15:0]  audio_sample_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [11:0]  best_index_o,
  output logic [13:0]  best_lag_o,
  output logic [47:0]  peak_score_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i
);

  localparam int LW = act_pkg::LW;
  localparam int HW = act_pkg::HW;
  localparam logic [48:0] SUM_MAX = {1'b0, {48{1'b1}}};

  logic [13:0] min_lag_q;
  logic [12:0] search_range_q;
  logic [9:0]  check_interval_q;
  logic [16:0] decay_factor_q;
  logic [6:0]  decay_interval_q;

  act_pkg::ctl_t ctl;
  logic          out_full;

  logic [47:0] lag_mem [act_pkg::LAG_COUNT];
  logic [14:0] hist_mem [act_pkg::HISTORY_DEPTH];

  logic [HW-1:0] wp_q;
  logic [14:0]   smp_q;
  logic [47:0]   la_q, lb_q;
  logic [14:0]   hd_q;
  logic [LW-1:0] k1_q;
  logic [11:0]   sk_q;
  logic          fb_q;
  logic [47:0]   best_q;
  logic [11:0]   bidx_q;
  logic          out_valid_q;
  logic [11:0]   oidx_q;
  logic [13:0]   olag_q;
  logic [47:0]   oscore_q;

  logic [16:0]   mag;
  logic [14:0]   rect;
  logic [HW-1:0] wp_next;
  logic [31:0]   idx32, h32, b32;
  logic [HW-1:0] haddr;
  logic [LW-1:0] aaddr, baddr;
  logic          fb;
  logic [47:0]   op_a;
  logic [16:0]   op_b;
  logic [64:0]   prod;
  logic [48:0]   acc, dec, score;
  logic [47:0]   lag_wdata;
  logic          lag_we;
  logic [LW-1:0] lag_waddr;

  act_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .command_i        (command_i),
    .out_full_i       (out_full),
    .check_interval_i (check_interval_q),
    .decay_interval_i (decay_interval_q),
    .search_range_i   (search_range_q),
    .in_ready_o       (in_ready_o),
    .ctl_o            (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lag_q        <= 14'd551;
      search_range_q   <= 13'd2757;
      check_interval_q <= 10'd43;
      decay_factor_q   <= 17'd64225;
      decay_interval_q <= 7'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        act_pkg::REG_MIN_LAG:        min_lag_q        <= cfg_data_i[13:0];
        act_pkg::REG_SEARCH_RANGE:   search_range_q   <= cfg_data_i[12:0];
        act_pkg::REG_CHECK_INTERVAL: check_interval_q <= cfg_data_i[9:0];
        act_pkg::REG_DECAY_FACTOR:   decay_factor_q   <= cfg_data_i;
        act_pkg::REG_DECAY_INTERVAL: decay_interval_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // rectify and address generation
  always_comb begin
    mag     = audio_sample_i[15] ? 17'(-$signed({audio_sample_i[15], audio_sample_i}))
                                 : {1'b0, audio_sample_i};
    rect    = (mag > 17'd32767) ? 15'd32767 : mag[14:0];
    wp_next = wp_q + 1'b1;
    idx32   = 32'(ctl.idx);
    h32     = 32'(wp_q) - 32'(min_lag_q) - idx32;
    haddr   = h32[HW-1:0];
    aaddr   = idx32[LW-1:0];
    b32     = idx32 << 1;
    fb      = b32 < 32'(act_pkg::LAG_COUNT);
    baddr   = b32[LW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (ctl.hist_wr) begin
      wp_q <= wp_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.hist_wr) begin
      smp_q <= rect;
    end
    if (ctl.issue) begin
      k1_q <= aaddr;
      sk_q <= idx32[11:0];
      fb_q <= fb;
    end
  end

  // history ring
  always_ff @(posedge clk_i) begin
    if (ctl.hist_wr) begin
      hist_mem[wp_next] <= rect;
    end else if (ctl.issue && (ctl.mode == act_pkg::OP_CLEAR) &&
                 (idx32 < 32'(act_pkg::HISTORY_DEPTH))) begin
      hist_mem[idx32[HW-1:0]] <= '0;
    end
    if (ctl.issue) begin
      hd_q <= hist_mem[haddr];
    end
  end

  // shared multiplier and saturation
  always_comb begin
    if (ctl.mode == act_pkg::OP_DECAY) begin
      op_a = la_q;
      op_b = decay_factor_q;
    end else begin
      op_a = 48'(hd_q);
      op_b = 17'(smp_q);
    end
    prod  = 65'(op_a) * 65'(op_b);
    acc   = 49'(la_q) + 49'(prod[47:0]);
    dec   = (prod[64:16] > SUM_MAX) ? SUM_MAX : prod[64:16];
    score = 49'(la_q) + 49'(fb_q ? lb_q : 48'd0);
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (score > SUM_MAX) score = SUM_MAX;

    lag_we    = 1'b0;
    lag_waddr = k1_q;
    lag_wdata = acc[47:0];
    case (ctl.mode)
      act_pkg::OP_CLEAR: begin
        lag_we    = ctl.issue && (idx32 < 32'(act_pkg::LAG_COUNT));
        lag_waddr = aaddr;
        lag_wdata = '0;
      end
      act_pkg::OP_SAMPLE: lag_we = ctl.v1;
      act_pkg::OP_DECAY: begin
        lag_we    = ctl.v1;
        lag_wdata = dec[47:0];
      end
      default: lag_we = 1'b0;
    endcase
  end

  // lag sum table
  always_ff @(posedge clk_i) begin
    if (lag_we) begin
      lag_mem[lag_waddr] <= lag_wdata;
    end
    if (ctl.issue) begin
      la_q <= lag_mem[aaddr];
      lb_q <= lag_mem[baddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.search_start) begin
      best_q <= '0;
      bidx_q <= '0;
    end else if (ctl.v1 && (ctl.mode == act_pkg::OP_SEARCH) && (score[47:0] > best_q)) begin
      best_q <= score[47:0];
      bidx_q <= sk_q;
    end
  end

  // result register
  assign out_full = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.search_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.search_done) begin
      oidx_q   <= bidx_q;
      olag_q   <= min_lag_q + 14'(bidx_q);
      oscore_q <= best_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_index_o = oidx_q;
  assign best_lag_o   = olag_q;
  assign peak_score_o = oscore_q;

endmodule
